// File: src/itmh_pkg.sv
`timescale 1ns / 1ps

package itmh_pkg;

  localparam int HEAP_DEPTH    = 64;
  localparam int EVENT_HANDLES = 64;
  localparam int KEY_W         = 32;
  localparam int ID_W          = 6;
  localparam int SLOT_AW       = $clog2(HEAP_DEPTH);
  localparam int CNT_W         = $clog2(HEAP_DEPTH + 1);
  localparam int SLOT_W        = ID_W + KEY_W;
  localparam int IN_W          = 40;
  localparam int OUT_W         = 56;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_ALREADY    = 3'd1,
    ST_NOT_QUEUED = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INS,
    CMD_RM_RD,
    CMD_RM_GOT,
    CMD_POP_RD,
    CMD_POP_GOT,
    CMD_CLR,
    CMD_UP_RD,
    CMD_UP_MOVE,
    CMD_DN_RD,
    CMD_DN_MOVE,
    CMD_PLACE,
    CMD_TOP_RD,
    CMD_LOAD
  } dp_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RM_GOT,
    S_POP_GOT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_TOP_RD,
    S_LOAD
  } state_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e code;
  } dp_ctrl_t;

  typedef struct packed {
    op_e  op;
    logic vhit;
    logic full;
    logic empty;
    logic count_zero;
    logic at_zero;
    logic left_oob;
    logic up_less;
    logic dn_go;
    logic rm_last;
    logic pos_zero;
    logic out_busy;
  } dp_status_t;

endpackage

// File: src/itmh_ram.sv
`timescale 1ns / 1ps

module itmh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: src/itmh_ctrl.sv
`timescale 1ns / 1ps

module itmh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  itmh_pkg::dp_status_t st_i,
  output itmh_pkg::dp_ctrl_t   ctrl_o
);
  import itmh_pkg::*;

  state_e  state_q, state_d;
  status_e code_q, code_d;
  logic    from_rm_q, from_rm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      code_q    <= ST_DONE;
      from_rm_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      code_q    <= code_d;
      from_rm_q <= from_rm_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    from_rm_d   = from_rm_q;
    ctrl_o.cmd  = CMD_NONE;
    ctrl_o.code = code_q;
    s_tready_o  = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          ctrl_o.cmd = CMD_ACCEPT;
          code_d     = ST_DONE;
          from_rm_d  = 1'b0;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st_i.op)
          OP_INSERT: begin
            if (st_i.vhit) begin
              code_d  = ST_ALREADY;
              state_d = S_TOP_RD;
            end else if (st_i.full) begin
              code_d  = ST_FULL;
              state_d = S_TOP_RD;
            end else begin
              ctrl_o.cmd = CMD_INS;
              state_d    = S_UP_RD;
            end
          end
          OP_REMOVE: begin
            if (!st_i.vhit) begin
              code_d  = ST_NOT_QUEUED;
              state_d = S_TOP_RD;
            end else begin
              ctrl_o.cmd = CMD_RM_RD;
              state_d    = S_RM_GOT;
            end
          end
          OP_POP: begin
            if (st_i.empty) begin
              code_d  = ST_EMPTY;
              state_d = S_TOP_RD;
            end else begin
              ctrl_o.cmd = CMD_POP_RD;
              state_d    = S_POP_GOT;
            end
          end
          default: begin
            ctrl_o.cmd = CMD_CLR;
            state_d    = S_TOP_RD;
          end
        endcase
      end
      S_RM_GOT: begin
        ctrl_o.cmd = CMD_RM_GOT;
        if (st_i.rm_last) begin
          state_d = S_TOP_RD;
        end else if (st_i.pos_zero) begin
          state_d = S_DN_RD;
        end else begin
          from_rm_d = 1'b1;
          state_d   = S_UP_RD;
        end
      end
      S_POP_GOT: begin
        ctrl_o.cmd = CMD_POP_GOT;
        state_d    = st_i.count_zero ? S_TOP_RD : S_DN_RD;
      end
      S_UP_RD: begin
        if (st_i.at_zero) begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end else begin
          ctrl_o.cmd = CMD_UP_RD;
          state_d    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st_i.up_less) begin
          ctrl_o.cmd = CMD_UP_MOVE;
          from_rm_d  = 1'b0;
          state_d    = S_UP_RD;
        end else if (from_rm_q) begin
          from_rm_d = 1'b0;
          state_d   = S_DN_RD;
        end else begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end
      end
      S_DN_RD: begin
        if (st_i.left_oob) begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end else begin
          ctrl_o.cmd = CMD_DN_RD;
          state_d    = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (st_i.dn_go) begin
          ctrl_o.cmd = CMD_DN_MOVE;
          state_d    = S_DN_RD;
        end else begin
          ctrl_o.cmd = CMD_PLACE;
          state_d    = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        ctrl_o.cmd = CMD_TOP_RD;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        if (!st_i.out_busy) begin
          ctrl_o.cmd = CMD_LOAD;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/itmh_datapath.sv
`timescale 1ns / 1ps

module itmh_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  itmh_pkg::dp_ctrl_t             ctrl_i,
  output itmh_pkg::dp_status_t           st_o,
  input  logic [itmh_pkg::IN_W-1:0]      s_tdata_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [itmh_pkg::OUT_W-1:0]     m_tdata_o
);
  import itmh_pkg::*;

  op_e                 op_q;
  logic [ID_W-1:0]     id_q;
  logic [KEY_W-1:0]    key_q;
  logic [SLOT_AW-1:0]  at_q, at_d;
  logic [ID_W-1:0]     cev_q, cev_d;
  logic [KEY_W-1:0]    ckey_q, ckey_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [EVENT_HANDLES-1:0] valid_q, valid_d;
  logic                pv_q, pv_d;
  logic [ID_W-1:0]     pid_q, pid_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_q, out_d;

  logic [SLOT_AW-1:0]  ra, rb, wa;
  logic [SLOT_W-1:0]   rd_a, rd_b, wd;
  logic                we;
  logic [ID_W-1:0]     pos_ra;
  logic [SLOT_AW-1:0]  pos_rd, pos_rd_b;
  logic [SLOT_AW-1:0]  pos_wa, pos_wd;
  logic [ID_W-1:0]     pos_wa_ev;
  logic                pos_we;

  logic [ID_W-1:0]     a_ev, b_ev, ch_ev;
  logic [KEY_W-1:0]    a_key, b_key, ch_key;
  logic [CNT_W-1:0]    cm1;
  logic [SLOT_AW-1:0]  pm1, parent;
  logic [SLOT_AW+1:0]  lft, rgt, cnt_x;
  logic                use_l;
  logic [SLOT_AW-1:0]  child;

  assign a_ev   = rd_a[SLOT_W-1:KEY_W];
  assign a_key  = rd_a[KEY_W-1:0];
  assign b_ev   = rd_b[SLOT_W-1:KEY_W];
  assign b_key  = rd_b[KEY_W-1:0];
  assign cm1    = count_q - 1'b1;
  assign pm1    = at_q - 1'b1;
  assign parent = pm1 >> 1;
  assign lft    = {1'b0, at_q, 1'b1};
  assign rgt    = {1'b0, at_q, 1'b0} + (SLOT_AW + 2)'(2);
  assign cnt_x  = (SLOT_AW + 2)'(count_q);
  assign use_l  = (rgt >= cnt_x) || (a_key < b_key);
  assign child  = use_l ? lft[SLOT_AW-1:0] : rgt[SLOT_AW-1:0];
  assign ch_ev  = use_l ? a_ev : b_ev;
  assign ch_key = use_l ? a_key : b_key;
  assign pos_wa = pos_wa_ev[SLOT_AW-1:0];

  itmh_ram #(.WIDTH(SLOT_W), .DEPTH(HEAP_DEPTH)) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (wa),
    .wdata_i   (wd),
    .raddr_a_i (ra),
    .rdata_a_o (rd_a),
    .raddr_b_i (rb),
    .rdata_b_o (rd_b)
  );

  itmh_ram #(.WIDTH(SLOT_AW), .DEPTH(EVENT_HANDLES)) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (pos_we),
    .waddr_i   (pos_wa),
    .wdata_i   (pos_wd),
    .raddr_a_i (pos_ra),
    .rdata_a_o (pos_rd),
    .raddr_b_i (pos_ra),
    .rdata_b_o (pos_rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == CMD_ACCEPT) begin
      op_q  <= op_e'(s_tdata_i[1:0]);
      id_q  <= s_tdata_i[7:2];
      key_q <= s_tdata_i[39:8];
    end
    at_q   <= at_d;
    cev_q  <= cev_d;
    ckey_q <= ckey_d;
    pid_q  <= pid_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      valid_q     <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      valid_q     <= valid_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    at_d        = at_q;
    cev_d       = cev_q;
    ckey_d      = ckey_q;
    count_d     = count_q;
    valid_d     = valid_q;
    pv_d        = pv_q;
    pid_d       = pid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    ra          = '0;
    rb          = '0;
    we          = 1'b0;
    wa          = at_q;
    wd          = {cev_q, ckey_q};
    pos_ra      = id_q;
    pos_we      = 1'b0;
    pos_wa_ev   = cev_q;
    pos_wd      = at_q;
    case (ctrl_i.cmd)
      CMD_ACCEPT: begin
        pv_d  = 1'b0;
        pid_d = '0;
      end
      CMD_INS: begin
        at_d        = count_q[SLOT_AW-1:0];
        count_d     = count_q + 1'b1;
        valid_d[id_q] = 1'b1;
        cev_d       = id_q;
        ckey_d      = key_q;
      end
      CMD_RM_RD: begin
        ra            = cm1[SLOT_AW-1:0];
        count_d       = cm1;
        valid_d[id_q] = 1'b0;
      end
      CMD_RM_GOT: begin
        at_d   = pos_rd;
        cev_d  = a_ev;
        ckey_d = a_key;
      end
      CMD_POP_RD: begin
        ra      = '0;
        rb      = cm1[SLOT_AW-1:0];
        count_d = cm1;
      end
      CMD_POP_GOT: begin
        pv_d          = 1'b1;
        pid_d         = a_ev;
        valid_d[a_ev] = 1'b0;
        cev_d         = b_ev;
        ckey_d        = b_key;
        at_d          = '0;
      end
      CMD_CLR: begin
        valid_d = '0;
        count_d = '0;
      end
      CMD_UP_RD: begin
        ra = parent;
      end
      CMD_UP_MOVE: begin
        we        = 1'b1;
        wd        = rd_a;
        pos_we    = 1'b1;
        pos_wa_ev = a_ev;
        at_d      = parent;
      end
      CMD_DN_RD: begin
        ra = lft[SLOT_AW-1:0];
        rb = rgt[SLOT_AW-1:0];
      end
      CMD_DN_MOVE: begin
        we        = 1'b1;
        wd        = {ch_ev, ch_key};
        pos_we    = 1'b1;
        pos_wa_ev = ch_ev;
        at_d      = child;
      end
      CMD_PLACE: begin
        we     = 1'b1;
        pos_we = 1'b1;
      end
      CMD_TOP_RD: begin
        ra = '0;
      end
      CMD_LOAD: begin
        out_valid_d = 1'b1;
        out_d = {count_q,
                 (count_q != '0) ? a_key : '0,
                 (count_q != '0) ? a_ev : '0,
                 (count_q != '0),
                 pid_q, pv_q, ctrl_i.code};
      end
      default: begin
      end
    endcase
  end

  assign st_o.op         = op_q;
  assign st_o.vhit       = valid_q[id_q];
  assign st_o.full       = (count_q == CNT_W'(HEAP_DEPTH));
  assign st_o.empty      = (count_q == '0);
  assign st_o.count_zero = (count_q == '0);
  assign st_o.at_zero    = (at_q == '0);
  assign st_o.left_oob   = (lft >= cnt_x);
  assign st_o.up_less    = (ckey_q < a_key);
  assign st_o.dn_go      = (ch_key < ckey_q);
  assign st_o.rm_last    = (CNT_W'(pos_rd) == count_q);
  assign st_o.pos_zero   = (pos_rd_b == '0);
  assign st_o.out_busy   = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

// File: src/indexed_timeout_min_heap.sv
`timescale 1ns / 1ps

// Indexed min-heap of timer events keyed by timeout, up to 64 entries.
// The slave channel takes one command per transaction: insert, remove by
// handle, pop of the earliest event, or clear. The master channel returns
// exactly one result transaction per command with the status, the popped
// handle, the earliest entry after the command and the entry count.
// Rejected commands and clear walk no heap level; the other commands may sift,
// and the sift sequencer steps one level per read and compare pair over the
// slot memory.
// The block takes one command at a time; s_axis_tready is high only while
// it is idle. When the receiver stalls, the finished result stays in the
// output register, a new command is still taken, and it waits before its
// own result is written until the earlier one has been taken.
// Reset empties the heap and clears every queued flag at once; no
// clearing pass runs, and the block is ready as soon as reset is released.
module indexed_timeout_min_heap (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // op[1:0], event_id[7:2], timeout_key[39:8]
  input  logic [itmh_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[2:0], popped_valid[3], popped_id[9:4], top_valid[10],
  // top_id[16:11], top_key[48:17], entry_count[55:49]
  output logic [itmh_pkg::OUT_W-1:0]     m_axis_tdata
);
  import itmh_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t st;

  itmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .st_i       (st),
    .ctrl_o     (ctrl)
  );

  itmh_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .st_o       (st),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

// File: src/itmh_checker.sv
`timescale 1ns / 1ps

module itmh_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [itmh_pkg::OUT_W-1:0] m_axis_tdata
);
  import itmh_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command taken while busy");

  a_top_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10] == (m_axis_tdata[55:49] != '0)))
    else $error("top valid disagrees with count");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[55:49] <= 7'(HEAP_DEPTH)))
    else $error("count beyond depth");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> (m_axis_tdata[2:0] == ST_DONE))
    else $error("pop result with error status");

endmodule

bind indexed_timeout_min_heap itmh_checker u_itmh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_indexed_timeout_min_heap.sv
`timescale 1ns / 1ps

module tb_indexed_timeout_min_heap;
  import itmh_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    op_e              op;
  } cmd_t;

  typedef struct packed {
    logic [6:0]       count;
    logic [KEY_W-1:0] top_key;
    logic [ID_W-1:0]  top_id;
    logic             top_valid;
    logic [ID_W-1:0]  popped_id;
    logic             popped_valid;
    status_e          status;
  } rsp_t;

  typedef struct {
    op_e             op;
    int unsigned     id;
    logic [31:0]     key;
    bit              has_want;
    rsp_t            want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  indexed_timeout_min_heap u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [ID_W-1:0]  hp_ev[HEAP_DEPTH];
  logic [KEY_W-1:0] hp_key[HEAP_DEPTH];
  bit               queued[EVENT_HANDLES];
  int unsigned      pos_of[EVENT_HANDLES];
  int unsigned      hp_n;

  row_t        rows[$];
  rsp_t        pending_rsp[$];
  bit          pending_fixed[$];
  rsp_t        fixed_rsp[$];
  int          mismatches;
  int          stall_rx;
  bit          calm;
  longint      cycles;

  function automatic void add_row(row_t rw);
    rows = {rows, rw};
  endfunction

  function automatic void put_slot(int unsigned at, logic [ID_W-1:0] ev, logic [KEY_W-1:0] k);
    hp_ev[at] = ev;
    hp_key[at] = k;
    pos_of[ev] = at;
  endfunction

  function automatic void bubble_up(int unsigned at, logic [ID_W-1:0] ev,
                                    logic [KEY_W-1:0] k);
    int unsigned up;
    while (at != 0) begin
      up = (at - 1) >> 1;
      if (!(k < hp_key[up])) break;
      put_slot(at, hp_ev[up], hp_key[up]);
      at = up;
    end
    put_slot(at, ev, k);
  endfunction

  function automatic void bubble_down(int unsigned at, logic [ID_W-1:0] ev,
                                      logic [KEY_W-1:0] k);
    int unsigned ch;
    forever begin
      ch = (at + 1) << 1;
      if (ch >= hp_n || hp_key[ch-1] < hp_key[ch]) ch--;
      if (ch >= hp_n || !(hp_key[ch] < k)) break;
      put_slot(at, hp_ev[ch], hp_key[ch]);
      at = ch;
    end
    put_slot(at, ev, k);
  endfunction

  function automatic rsp_t heap_apply(op_e op, int unsigned id, logic [KEY_W-1:0] k);
    rsp_t r;
    int unsigned at;
    logic [ID_W-1:0] lev;
    logic [KEY_W-1:0] lk;
    r = '0;
    r.status = ST_DONE;
    case (op)
      OP_INSERT: begin
        if (queued[id]) r.status = ST_ALREADY;
        else if (hp_n >= HEAP_DEPTH) r.status = ST_FULL;
        else begin
          at = hp_n;
          hp_n++;
          queued[id] = 1'b1;
          bubble_up(at, ID_W'(id), k);
        end
      end
      OP_REMOVE: begin
        if (!queued[id] || pos_of[id] >= hp_n) r.status = ST_NOT_QUEUED;
        else begin
          at = pos_of[id];
          hp_n--;
          lev = hp_ev[hp_n];
          lk = hp_key[hp_n];
          queued[id] = 1'b0;
          if (at != hp_n) begin
            if (at != 0 && lk < hp_key[(at-1)>>1]) bubble_up(at, lev, lk);
            else bubble_down(at, lev, lk);
          end
        end
      end
      OP_POP: begin
        if (hp_n == 0) r.status = ST_EMPTY;
        else begin
          hp_n--;
          queued[hp_ev[0]] = 1'b0;
          r.popped_valid = 1'b1;
          r.popped_id = hp_ev[0];
          if (hp_n != 0) bubble_down(0, hp_ev[hp_n], hp_key[hp_n]);
        end
      end
      default: begin
        for (int unsigned i = 0; i < hp_n; i++) queued[hp_ev[i]] = 1'b0;
        hp_n = 0;
      end
    endcase
    if (hp_n != 0) begin
      r.top_valid = 1'b1;
      r.top_id = hp_ev[0];
      r.top_key = hp_key[0];
    end
    r.count = 7'(hp_n);
    return r;
  endfunction

  function automatic rsp_t mk(status_e s, bit pv, int pid, bit tv, int tid,
                              logic [31:0] tk, int cnt);
    rsp_t r;
    r.status = s;
    r.popped_valid = pv;
    r.popped_id = ID_W'(pid);
    r.top_valid = tv;
    r.top_id = ID_W'(tid);
    r.top_key = tk;
    r.count = 7'(cnt);
    return r;
  endfunction

  task automatic send_cmd(op_e op, int unsigned id, logic [31:0] k,
                          bit has_want, rsp_t want);
    cmd_t c;
    rsp_t p;
    c.op = op;
    c.id = ID_W'(id);
    c.key = k;
    s_axis_tdata <= c;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    p = heap_apply(op, id, k);
    pending_rsp = {pending_rsp, p};
    pending_fixed = {pending_fixed, has_want};
    if (has_want) fixed_rsp = {fixed_rsp, want};
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic report(string what, rsp_t w, rsp_t g);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %p got %p", what, w, g);
  endtask

  always @(posedge clk_i) begin
    rsp_t got, want;
    bit fx;
    cycles <= cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_rsp.pop_front();
        fx = pending_fixed.pop_front();
        if (got.status != want.status || got.popped_valid != want.popped_valid ||
            got.popped_id != want.popped_id || got.top_valid != want.top_valid ||
            got.top_id != want.top_id || got.top_key != want.top_key ||
            got.count != want.count)
          report("vs predictor", want, got);
        if (fx) begin
          want = fixed_rsp.pop_front();
          if (got !== want) report("vs table", want, got);
        end
      end
    end
    if (!calm && stall_rx == 0 && $urandom_range(0, 7) == 0)
      stall_rx <= $urandom_range(1, 15);
    else if (stall_rx != 0)
      stall_rx <= stall_rx - 1;
    m_axis_tready <= calm || (stall_rx == 0);
  end

  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("FAIL indexed_timeout_min_heap");
      $finish;
    end
  end

  initial begin
    row_t rw;
    rsp_t none;
    int unsigned id;
    int unsigned r;
    logic [31:0] k;
    mismatches = 0;
    stall_rx = 0;
    calm = 0;
    cycles = 0;
    hp_n = 0;
    none = '0;
    foreach (queued[i]) begin
      queued[i] = 0;
      pos_of[i] = 0;
    end

    add_row('{OP_POP, 0, 32'd0, 1, mk(ST_EMPTY, 0, 0, 0, 0, 0, 0)});
    add_row('{OP_REMOVE, 63, 32'd0, 1, mk(ST_NOT_QUEUED, 0, 0, 0, 0, 0, 0)});
    add_row('{OP_CLEAR, 0, 32'd0, 1, mk(ST_DONE, 0, 0, 0, 0, 0, 0)});
    add_row('{OP_INSERT, 63, 32'hFFFF_FFFF, 1,
              mk(ST_DONE, 0, 0, 1, 63, 32'hFFFF_FFFF, 1)});
    add_row('{OP_INSERT, 63, 32'd5, 1,
              mk(ST_ALREADY, 0, 0, 1, 63, 32'hFFFF_FFFF, 1)});
    add_row('{OP_POP, 0, 32'd0, 1, mk(ST_DONE, 1, 63, 0, 0, 0, 0)});
    add_row('{OP_INSERT, 0, 32'd0, 1, mk(ST_DONE, 0, 0, 1, 0, 0, 1)});
    add_row('{OP_INSERT, 1, 32'd0, 0, none});
    add_row('{OP_INSERT, 2, 32'd0, 0, none});
    add_row('{OP_INSERT, 3, 32'hAAAA_5555, 0, none});
    add_row('{OP_INSERT, 4, 32'h5555_AAAA, 0, none});
    add_row('{OP_REMOVE, 4, 32'd0, 0, none});
    add_row('{OP_REMOVE, 0, 32'd0, 0, none});
    add_row('{OP_REMOVE, 0, 32'd0, 0, none});
    add_row('{OP_POP, 0, 32'd0, 0, none});
    add_row('{OP_CLEAR, 0, 32'd0, 1, mk(ST_DONE, 0, 0, 0, 0, 0, 0)});
    for (int i = 0; i < 64; i++) add_row('{OP_INSERT, i, 32'(63 - i), 0, none});
    add_row('{OP_INSERT, 5, 32'd1, 1, mk(ST_ALREADY, 0, 0, 1, 63, 0, 64)});
    add_row('{OP_POP, 0, 32'd0, 0, none});
    add_row('{OP_INSERT, 63, 32'd9, 0, none});
    add_row('{OP_REMOVE, 10, 32'd9, 0, none});
    add_row('{OP_INSERT, 40, 32'd7, 1, mk(ST_ALREADY, 0, 0, 1, 62, 1, 63)});
    add_row('{OP_INSERT, 10, 32'd7, 0, none});
    add_row('{OP_INSERT, 11, 32'd7, 1, mk(ST_ALREADY, 0, 0, 1, 62, 1, 64)});
    add_row('{OP_CLEAR, 0, 32'd0, 1, mk(ST_DONE, 0, 0, 0, 0, 0, 0)});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      rw = rows[i];
      send_cmd(rw.op, rw.id, rw.key, rw.has_want, rw.want);
    end
    drain();

    for (int n = 0; n < 762; n++) begin
      if (n == 700) begin
        drain();
        calm = 1;
      end
      if (n == 400) drain();
      r = $urandom_range(0, 99);
      id = $urandom_range(0, 63);
      case ($urandom_range(0, 3))
        0: k = $urandom();
        1: k = $urandom_range(0, 15);
        2: k = 32'hFFFF_FFF0 | $urandom_range(0, 15);
        default: k = {2'($urandom_range(0, 3)), 30'd0} | 32'($urandom_range(0, 3));
      endcase
      if (r < 50) send_cmd(OP_INSERT, id, k, 0, none);
      else if (r < 72) send_cmd(OP_REMOVE, id, k, 0, none);
      else if (r < 97) send_cmd(OP_POP, id, k, 0, none);
      else if (r < 98 || hp_n > 40) send_cmd(OP_CLEAR, id, k, 0, none);
      else send_cmd(OP_INSERT, id, k, 0, none);
    end
    drain();
    repeat (40) @(posedge clk_i);

    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("PASS indexed_timeout_min_heap");
    else
      $display("FAIL indexed_timeout_min_heap");
    $finish;
  end

endmodule

// File: filelist.f
src/itmh_pkg.sv
src/itmh_ram.sv
src/itmh_ctrl.sv
src/itmh_datapath.sv
src/indexed_timeout_min_heap.sv
src/itmh_checker.sv
tb/tb_indexed_timeout_min_heap.sv
